FILE: sv/rdp_pkg.sv
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared types and constants for the rational decimal period block.
// ----------------------------------------------------------------------------
`default_nettype none
package rdp_pkg;

  localparam logic [2:0] ST_UNDEF    = 3'd0;
  localparam logic [2:0] ST_PINF     = 3'd1;
  localparam logic [2:0] ST_NINF     = 3'd2;
  localparam logic [2:0] ST_ZERO     = 3'd3;
  localparam logic [2:0] ST_TERM     = 3'd4;
  localparam logic [2:0] ST_REPEAT   = 3'd5;
  localparam logic [2:0] ST_TOOLARGE = 3'd6;
  localparam logic [2:0] ST_NOTLOAD  = 3'd7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [30:0] INT_PART_MAX = 31'h7FFF_FFFF;

  // Request and answer of the shared restoring divider.
  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quotient;
    logic [32:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: sv/rdp_div.sv
// ----------------------------------------------------------------------------
// rdp_div
// Restoring divider, one quotient bit per cycle, 33 bit unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none
module rdp_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rdp_pkg::div_req_t req,
  output rdp_pkg::div_rsp_t      rsp
);
  import rdp_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [32:0] quo;
  logic [32:0] rem;
  logic [32:0] dvs;
  logic [33:0] trial;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem, quo[32]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd33;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (trial[33]) begin
          rem <= {rem[31:0], quo[32]};
          quo <= {quo[31:0], 1'b0};
        end else begin
          rem <= trial[32:0];
          quo <= {quo[31:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo, rem};

endmodule
`default_nettype wire

FILE: sv/rational_decimal_period_top.sv
// ----------------------------------------------------------------------------
// rational_decimal_period_top
// Exact decimal expansion of a signed fraction with period detection.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_stall) carries op, numerator,
// denominator and position; one output channel (out_valid/out_stall)
// carries one result beat per input beat.
// A load with a zero numerator or denominator goes straight to its
// result. Any other load clears the first-seen memory one entry a
// cycle, runs a shared divider pass for the integer part, then one
// divider pass per fraction digit. An exact or oversize load stops after
// the integer part. A query answers directly when its digit is zero by
// rule, reads the digit memory for a direct digit and runs a divider
// pass first when the position wraps into the period.
// One item is in work at a time; in_stall is high in reset, while busy and
// while a result beat waits, so the next beat is taken the cycle after the
// result beat leaves. A stalled result holds its payload.
// Reset returns status "not loaded"; the digit memory is undefined until a
// load writes it.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_decimal_period_top #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               op,
  input  wire logic signed [31:0] numerator,
  input  wire logic signed [31:0] denominator,
  input  wire logic        [15:0] position,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [2:0]  status,
  output logic                    negative,
  output logic             [30:0] integer_part,
  output logic             [12:0] preperiod_length,
  output logic             [11:0] period_length,
  output logic             [3:0]  digit
);
  import rdp_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(TABLE_DEPTH + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_INTDIV, S_MARK, S_DIGDIV, S_CHECK, S_LOOK,
    S_QDIV, S_QREAD, S_QOUT, S_OUT
  } state_t;

  state_t state;

  // memories
  logic [3:0]    dmem [TABLE_DEPTH];
  logic [PW-1:0] fmem [TABLE_DEPTH];
  logic [PW-1:0] f_rd;
  logic [3:0]    d_rd;

  // held results
  logic [2:0]    h_status;
  logic          h_neg;
  logic [30:0]   h_int;
  logic [12:0]   h_pre;
  logic [11:0]   h_per;

  // work registers
  logic [32:0]   nmag;
  logic [32:0]   dmag;
  logic [32:0]   rem;
  logic [PW-1:0] k;
  logic [AW-1:0] clr;
  logic [15:0]   qpos;
  logic          started;

  div_req_t      dreq;
  div_rsp_t      drsp;

  rdp_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [32:0] n_abs, d_abs;
  assign n_abs = numerator[31]   ? 33'(-{1'b1, numerator})   : {1'b0, numerator};
  assign d_abs = denominator[31] ? 33'(-{1'b1, denominator}) : {1'b0, denominator};

  assign in_stall = rst || (state != S_IDLE) || out_valid;

  // divider request from the sequencer, start pulses on the first cycle
  always_comb begin
    dreq = '0;
    case (state)
      S_INTDIV: begin
        dreq.start    = !started;
        dreq.dividend = nmag;
        dreq.divisor  = dmag;
      end
      S_DIGDIV: begin
        dreq.start    = !started;
        dreq.dividend = 33'(rem * 33'd10);
        dreq.divisor  = dmag;
      end
      S_QDIV: begin
        dreq.start    = !started;
        dreq.dividend = 33'(qpos - 16'(h_pre));
        dreq.divisor  = 33'(h_per);
      end
      default: dreq = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      h_status  <= ST_NOTLOAD;
      h_neg     <= 1'b0;
      h_int     <= '0;
      h_pre     <= '0;
      h_per     <= '0;
      started   <= 1'b0;
      digit     <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            digit <= '0;
            if (op == OP_LOAD) begin
              nmag  <= n_abs;
              dmag  <= d_abs;
              h_int <= '0;
              h_pre <= '0;
              h_per <= '0;
              clr   <= '0;
              if (d_abs == '0) begin
                h_status <= (n_abs == '0) ? ST_UNDEF :
                            (numerator[31] ? ST_NINF : ST_PINF);
                h_neg    <= (n_abs != '0) && numerator[31];
                state    <= S_OUT;
              end else if (n_abs == '0) begin
                h_status <= ST_ZERO;
                h_neg    <= 1'b0;
                state    <= S_OUT;
              end else begin
                h_status <= ST_TERM;
                h_neg    <= numerator[31] ^ denominator[31];
                state    <= S_CLEAR;
              end
            end else begin
              // digit index from zero; unused when the answer is zero
              qpos <= position - 16'd1;
              if (position == '0 ||
                  !(h_status == ST_TERM || h_status == ST_REPEAT)) begin
                state <= S_OUT;
              end else if (h_status == ST_TERM) begin
                state <= (position > 16'(h_pre)) ? S_OUT : S_QREAD;
              end else if (position - 16'd1 < 16'(h_pre)) begin
                state <= S_QREAD;
              end else begin
                started <= 1'b0;
                state   <= S_QDIV;
              end
            end
          end
        end
        // sweep the first-seen memory
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(TABLE_DEPTH - 1)) begin
            started <= 1'b0;
            state   <= S_INTDIV;
          end
        end
        S_INTDIV: begin
          started <= 1'b1;
          if (drsp.done && started) begin
            h_int <= (drsp.quotient > 33'(INT_PART_MAX)) ? INT_PART_MAX
                                                         : drsp.quotient[30:0];
            rem   <= drsp.remainder;
            k     <= PW'(1);
            if (dmag > 33'(TABLE_DEPTH)) begin
              h_status <= ST_TOOLARGE;
              state    <= S_OUT;
            end else if (drsp.remainder == '0) begin
              state <= S_OUT;
            end else begin
              state <= S_MARK;
            end
          end
        end
        // record the initial remainder at position 1
        S_MARK: begin
          started <= 1'b0;
          state   <= S_DIGDIV;
        end
        S_DIGDIV: begin
          started <= 1'b1;
          if (drsp.done && started) begin
            rem   <= drsp.remainder;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rem == '0) begin
            h_pre <= 13'(k);
            state <= S_OUT;
          end else begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (f_rd != '0) begin
            h_status <= ST_REPEAT;
            h_pre    <= 13'(f_rd - PW'(1));
            h_per    <= 12'(k - (f_rd - PW'(1)));
            state    <= S_OUT;
          end else if (k == PW'(TABLE_DEPTH)) begin
            state <= S_OUT;
          end else begin
            k       <= k + PW'(1);
            started <= 1'b0;
            state   <= S_DIGDIV;
          end
        end
        // wrap the index into the period
        S_QDIV: begin
          started <= 1'b1;
          if (drsp.done && started) begin
            qpos  <= 16'(h_pre) + drsp.remainder[15:0];
            state <= S_QREAD;
          end
        end
        S_QREAD: state <= S_QOUT;
        S_QOUT: begin
          digit <= d_rd;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) fmem[clr] <= '0;
    else if (state == S_MARK) fmem[rem[AW-1:0]] <= PW'(1);
    else if (state == S_LOOK && f_rd == '0) fmem[rem[AW-1:0]] <= k + PW'(1);
    f_rd <= fmem[drsp.remainder[AW-1:0]];
    if (state == S_DIGDIV && drsp.done && started)
      dmem[AW'(k - PW'(1))] <= drsp.quotient[3:0];
    d_rd <= dmem[qpos[AW-1:0]];
  end

  // held summary drives the result fields
  always_comb begin
    status           = h_status;
    negative         = h_neg;
    integer_part     = h_int;
    preperiod_length = h_pre;
    period_length    = h_per;
  end

endmodule
`default_nettype wire
